// ===== rtl/core/pcm_pkg.sv =====
// Shared widths, register indexes and pipeline constants of the perspective coordinate map.
`default_nettype none
package pcm_pkg;
	// Input coordinate width and the widths of the fixed-point terms.
	localparam int CoordW = 12;
	localparam int CoefW = 32;
	localparam int OffW = 40;
	localparam int ProdW = CoefW + CoordW + 1;
	localparam int SumW = 48;
	localparam int QuotW = 32;
	localparam int OutW = 16;

	// Configuration port.
	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 64;

	localparam logic [CfgAddrW-1:0] REG_LIN_X = 3'd0;
	localparam logic [CfgAddrW-1:0] REG_LIN_Y = 3'd1;
	localparam logic [CfgAddrW-1:0] REG_OFF_X = 3'd2;
	localparam logic [CfgAddrW-1:0] REG_OFF_Y = 3'd3;
	localparam logic [CfgAddrW-1:0] REG_PERSP = 3'd4;
	localparam logic [CfgAddrW-1:0] REG_DEN_OFF = 3'd5;

	localparam logic [63:0] LIN_X_RESET = 64'h0100_0000_0000_0000;
	localparam logic [63:0] LIN_Y_RESET = 64'h0000_0000_0100_0000;
	localparam logic [31:0] DEN_OFF_RESET = 32'h0100_0000;

	// Divider: one setup stage, one stage per quotient bit, one rounding stage.
	localparam int DivStages = QuotW + 2;
endpackage
`default_nettype wire

// ===== rtl/core/perspective_coordinate_map_core.sv =====
// Top level of the perspective coordinate map: registers, products, sums and output fields.
//
// A request passes the product, sum, sign, divider and output stages; one request can be accepted
// in every cycle unless in_stall is high. Each stage holds a valid bit and loads whenever it is empty
// or its successor moves, so bubbles close up and a stalled output does not block an empty input stage.
// Reset clears all valid bits and returns the matrix registers to the identity transform.
`default_nettype none
module perspective_coordinate_map_core #(
	parameter int TABLE_BITS = 5,
	parameter int MAX_DIM = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [pcm_pkg::CfgAddrW-1:0]  cfg_addr,
	input  wire logic [pcm_pkg::CfgDataW-1:0]  cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [pcm_pkg::CoordW-1:0]    dst_x,
	input  wire logic [pcm_pkg::CoordW-1:0]    dst_y,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [pcm_pkg::OutW-1:0]    src_x,
	output logic signed [pcm_pkg::OutW-1:0]    src_y,
	output logic [2*TABLE_BITS-1:0]            frac_index
);
	import pcm_pkg::*;

	// Dividend: numerator magnitude scaled by 2^(8+TABLE_BITS).
	localparam int NW = SumW + 8 + TABLE_BITS;
	localparam int DivBase = 3;
	localparam int NS = DivBase + DivStages + 1;

	// Configuration registers.
	logic [63:0]       lin_x_q;
	logic [63:0]       lin_y_q;
	logic [OffW-1:0]   off_x_q;
	logic [OffW-1:0]   off_y_q;
	logic [63:0]       persp_q;
	logic [CoefW-1:0]  den_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_x_q   <= LIN_X_RESET;
			lin_y_q   <= LIN_Y_RESET;
			off_x_q   <= '0;
			off_y_q   <= '0;
			persp_q   <= '0;
			den_off_q <= DEN_OFF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_LIN_X:   lin_x_q   <= cfg_data;
				REG_LIN_Y:   lin_y_q   <= cfg_data;
				REG_OFF_X:   off_x_q   <= cfg_data[OffW-1:0];
				REG_OFF_Y:   off_y_q   <= cfg_data[OffW-1:0];
				REG_PERSP:   persp_q   <= cfg_data;
				REG_DEN_OFF: den_off_q <= cfg_data[CoefW-1:0];
				default: ;
			endcase
		end
	end

	// Stage control: a stage loads when it is empty or its contents move on.
	logic [NS-1:0] vld_q;
	logic [NS:0]   rdy;

	assign rdy[NS] = !out_stall;
	for (genvar k = 0; k < NS; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall = !rdy[0];
	assign out_valid = vld_q[NS-1];

	// Coordinates beyond the frame are held to its last row or column.
	logic [CoordW-1:0] x_c;
	logic [CoordW-1:0] y_c;
	logic signed [CoordW:0] xs;
	logic signed [CoordW:0] ys;

	assign x_c = (int'(dst_x) >= MAX_DIM) ? CoordW'(MAX_DIM - 1) : dst_x;
	assign y_c = (int'(dst_y) >= MAX_DIM) ? CoordW'(MAX_DIM - 1) : dst_y;
	assign xs = $signed({1'b0, x_c});
	assign ys = $signed({1'b0, y_c});

	// Stage 1: the six coefficient products, one multiplier each.
	logic signed [ProdW-1:0] p0_s1, p1_s1, p3_s1, p4_s1, p6_s1, p7_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			p0_s1 <= $signed(lin_x_q[63:32]) * xs;
			p1_s1 <= $signed(lin_x_q[31:0]) * ys;
			p3_s1 <= $signed(lin_y_q[63:32]) * xs;
			p4_s1 <= $signed(lin_y_q[31:0]) * ys;
			p6_s1 <= $signed(persp_q[63:32]) * xs;
			p7_s1 <= $signed(persp_q[31:0]) * ys;
		end
	end

	// Stage 2: numerators at scale 2^-24 and the denominator at scale 2^-32.
	logic signed [SumW-1:0] nx_s2, ny_s2, d_s2;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			nx_s2 <= SumW'(p0_s1) + SumW'(p1_s1) + SumW'($signed(off_x_q));
			ny_s2 <= SumW'(p3_s1) + SumW'(p4_s1) + SumW'($signed(off_y_q));
			d_s2  <= SumW'(p6_s1) + SumW'(p7_s1)
				+ (SumW'($signed(den_off_q)) <<< 8);
		end
	end

	// Stage 3: split into magnitudes and signs for the unsigned dividers.
	logic [SumW-1:0] nxm_s3, nym_s3, dm_s3;
	logic            negx_s3, negy_s3, zero_s3;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			nxm_s3  <= nx_s2[SumW-1] ? SumW'(-nx_s2) : nx_s2;
			nym_s3  <= ny_s2[SumW-1] ? SumW'(-ny_s2) : ny_s2;
			dm_s3   <= d_s2[SumW-1] ? SumW'(-d_s2) : d_s2;
			negx_s3 <= nx_s2[SumW-1] ^ d_s2[SumW-1];
			negy_s3 <= ny_s2[SumW-1] ^ d_s2[SumW-1];
			zero_s3 <= d_s2 == '0;
		end
	end

	// Two dividers run side by side on the shared denominator.
	logic [QuotW-1:0] qx;
	logic [QuotW-1:0] qy;

	pcm_div #(.NW(NW)) u_div_x (
		.clk  (clk),
		.en   (rdy[DivBase +: DivStages]),
		.num  ({nxm_s3, {(8 + TABLE_BITS){1'b0}}}),
		.den  (dm_s3),
		.neg  (negx_s3),
		.zero (zero_s3),
		.quot (qx)
	);

	pcm_div #(.NW(NW)) u_div_y (
		.clk  (clk),
		.en   (rdy[DivBase +: DivStages]),
		.num  ({nym_s3, {(8 + TABLE_BITS){1'b0}}}),
		.den  (dm_s3),
		.neg  (negy_s3),
		.zero (zero_s3),
		.quot (qy)
	);

	// Output stage: integer part by arithmetic shift, fractions form the table index.
	logic signed [QuotW-1:0] ix;
	logic signed [QuotW-1:0] iy;

	assign ix = $signed(qx) >>> TABLE_BITS;
	assign iy = $signed(qy) >>> TABLE_BITS;

	always_ff @(posedge clk) begin
		if (rdy[NS-1]) begin
			src_x      <= ix[OutW-1:0];
			src_y      <= iy[OutW-1:0];
			frac_index <= {qy[TABLE_BITS-1:0], qx[TABLE_BITS-1:0]};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/pcm_div.sv =====
// Pipelined restoring divider with round-to-nearest and signed 32-bit saturation.
`default_nettype none
module pcm_div #(
	parameter int NW = 61
) (
	input  wire logic                          clk,
	input  wire logic [pcm_pkg::DivStages-1:0] en,
	input  wire logic [NW-1:0]                 num,
	input  wire logic [pcm_pkg::SumW-1:0]      den,
	input  wire logic                          neg,
	input  wire logic                          zero,
	output logic [pcm_pkg::QuotW-1:0]          quot
);
	import pcm_pkg::*;

	localparam int HiW = NW - QuotW;

	logic [SumW-1:0]  rem_s  [0:QuotW];
	logic [QuotW-1:0] lo_s   [0:QuotW];
	logic [QuotW-1:0] q_s    [0:QuotW];
	logic [SumW-1:0]  den_s  [0:QuotW];
	logic             neg_s  [0:QuotW];
	logic             zero_s [0:QuotW];
	logic             ovf_s  [0:QuotW];
	logic [SumW-1:0]  hi_ext;
	logic [QuotW:0]   q_rnd;
	logic             rnd_up;

	assign hi_ext = {{(SumW - HiW){1'b0}}, num[NW-1:QuotW]};

	// Setup: a quotient of 2^32 or more saturates, so the high part must stay below the divisor.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0]  <= hi_ext;
			lo_s[0]   <= num[QuotW-1:0];
			q_s[0]    <= '0;
			den_s[0]  <= den;
			neg_s[0]  <= neg;
			zero_s[0] <= zero;
			ovf_s[0]  <= hi_ext >= den;
		end
	end

	for (genvar k = 1; k <= QuotW; k++) begin : g_step
		logic [SumW:0] trial;
		logic          ge;

		assign trial = {rem_s[k-1], lo_s[k-1][QuotW-1]};
		assign ge = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]  <= ge ? SumW'(trial - {1'b0, den_s[k-1]}) : trial[SumW-1:0];
				lo_s[k]   <= {lo_s[k-1][QuotW-2:0], 1'b0};
				q_s[k]    <= {q_s[k-1][QuotW-2:0], ge};
				den_s[k]  <= den_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				zero_s[k] <= zero_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
			end
		end
	end

	// Ties round away from zero: step up when twice the remainder reaches the divisor.
	assign rnd_up = {rem_s[QuotW], 1'b0} >= {1'b0, den_s[QuotW]};
	assign q_rnd = {1'b0, q_s[QuotW]} + {{QuotW{1'b0}}, rnd_up};

	always_ff @(posedge clk) begin
		if (en[DivStages-1]) begin
			priority if (zero_s[QuotW]) begin
				quot <= '0;
			end else if (ovf_s[QuotW]) begin
				quot <= neg_s[QuotW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else if (neg_s[QuotW]) begin
				quot <= (q_rnd >= 33'h0_8000_0000) ? 32'h8000_0000
					: QuotW'(33'd0 - q_rnd);
			end else begin
				quot <= (q_rnd > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q_rnd[QuotW-1:0];
			end
		end
	end
endmodule
`default_nettype wire
